FILE: sv/lzpd_pkg.sv
package lzpd_pkg;

  localparam int HistoryDepth = 65536;
  localparam int HistAw       = $clog2(HistoryDepth);
  localparam int MaxPixels    = 16777216;
  localparam int CntW         = 25;
  localparam int LenW         = 24;

  localparam logic [CntW-1:0] MAX_PIXELS_C = CntW'(MaxPixels);
  localparam logic [LenW-1:0] LEN_MAX      = {LenW{1'b1}};
  localparam logic [16:0]     LONG_MARK    = 17'(31 << 8);
  localparam logic [16:0]     LONG_BASE    = 17'd8192;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OFS   = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [1:0] REG_ALPHA_ONLY   = 2'd0;
  localparam logic [1:0] REG_FORCE_OPAQUE = 2'd1;
  localparam logic [1:0] REG_TOTAL        = 2'd2;

  typedef enum logic [8:0] {
    PH_CTRL    = 9'b000000001,
    PH_LIT0    = 9'b000000010,
    PH_LIT1    = 9'b000000100,
    PH_LIT2    = 9'b000001000,
    PH_EXT     = 9'b000010000,
    PH_OFS     = 9'b000100000,
    PH_LONG_HI = 9'b001000000,
    PH_LONG_LO = 9'b010000000,
    PH_COPY    = 9'b100000000
  } phase_t;

  // one pixel write from the parser to the history memory
  typedef struct packed {
    logic              en;
    logic [HistAw-1:0] addr;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic [7:0]        a;
    logic              cw;
    logic              aw;
  } hist_wr_t;

endpackage

FILE: sv/lzpd_history.sv
module lzpd_history (
  input  logic                    clk,
  input  lzpd_pkg::hist_wr_t      wr,
  input  logic                    rd_en,
  input  logic [lzpd_pkg::HistAw-1:0] rd_addr,
  output logic [31:0]             rd_data
);
  import lzpd_pkg::*;

  // separate lanes so partial writes need no read-modify-write
  logic [23:0] colour_mem [HistoryDepth];
  logic [7:0]  alpha_mem  [HistoryDepth];
  logic [23:0] colour_q;
  logic [7:0]  alpha_q;

  // read data holds while the consumer is stalled
  always_ff @(posedge clk) begin
    if (wr.en && wr.cw) begin
      colour_mem[wr.addr] <= {wr.b2, wr.b1, wr.b0};
    end
    if (rd_en) begin
      colour_q <= colour_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.aw) begin
      alpha_mem[wr.addr] <= wr.a;
    end
    if (rd_en) begin
      alpha_q <= alpha_mem[rd_addr];
    end
  end

  assign rd_data = {alpha_q, colour_q};

endmodule

FILE: sv/lz_pixel_decompressor_core.sv
// LZ pixel decompressor.
// Input channel (in_*): one transfer is one tick: frame_start, byte_valid and
// stream_byte. Output channel (out_*): one transfer per input tick carries
// byte_taken, pixel emission, lane write enables, frame_done and error_code.
// From input transfer to output valid a tick passes the stage-1 register,
// which takes the history read issued with the tick, then the output register.
// Throughput is one tick per cycle unless out_stall holds the pipeline; the
// decode state lives in registers, the pixel history in a 64K-entry synchronous
// RAM. A copy reads a source pixel that may have been written by the tick just
// before: that pixel is forwarded from the previous write instead of the RAM.
// Copies consume ticks without taking the offered byte (byte_taken low).
// in_stall rises whenever the output register is full and out_stall is high,
// so the pipeline holds as a whole; no transfer is lost.
// Reset: registers take their reset values (alpha_only 0, force_opaque 1,
// total_pixels 1), decode state clears; history content is undefined until
// written. Configuration is via an APB-style port; pready is always high.
module lz_pixel_decompressor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_frame_start,
  input  logic        in_byte_valid,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_taken,
  output logic        out_pixel_valid,
  output logic [23:0] out_pixel_index,
  output logic [7:0]  out_out_byte0,
  output logic [7:0]  out_out_byte1,
  output logic [7:0]  out_out_byte2,
  output logic [7:0]  out_alpha_value,
  output logic        out_colour_write,
  output logic        out_alpha_write,
  output logic        out_frame_done,
  output logic [1:0]  out_error_code,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lzpd_pkg::*;

  // configuration
  logic            alpha_only_r, force_opaque_r;
  logic [CntW-1:0] total_r;
  logic [1:0]      reg_idx;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_only_r   <= 1'b0;
      force_opaque_r <= 1'b1;
      total_r        <= CntW'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        REG_ALPHA_ONLY:   alpha_only_r   <= cfg_pwdata[0];
        REG_FORCE_OPAQUE: force_opaque_r <= cfg_pwdata[0];
        REG_TOTAL:        total_r        <= cfg_pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALPHA_ONLY:   cfg_prdata = {31'd0, alpha_only_r};
      REG_FORCE_OPAQUE: cfg_prdata = {31'd0, force_opaque_r};
      REG_TOTAL:        cfg_prdata = {7'd0, total_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // stage control: s1 = copy read in flight, output register after
  logic s1_v_r, out_v_r, adv, fire;
  assign adv      = !(out_v_r && out_stall);
  assign in_stall = !adv;
  assign fire     = in_valid && adv;
  assign out_valid = out_v_r;

  // decode state
  phase_t          ph_r, ph_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [16:0]     mofs_r, mofs_nxt;
  logic [5:0]      lits_r, lits_nxt;
  logic [15:0]     gat_r, gat_nxt;
  logic [23:0]     src_r, src_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // per-tick result, pending pixel data for copies (filled from RAM or forwarded in s1)
  typedef struct packed {
    logic        taken;
    logic        pv;
    logic [23:0] idx;
    logic [7:0]  b0, b1, b2, a;
    logic        cw, aw;
    logic        done;
    logic [1:0]  err;
    logic        is_copy;
    logic        fwd;
  } res_t;

  res_t     r_nxt, s1_r, out_r, out_nxt;
  hist_wr_t wr_c;
  logic [HistAw-1:0] rd_addr;
  logic [31:0]       rd_data;
  logic [CntW-1:0]   total;

  // the pixel write of the stage-1 tick, copy data resolved from RAM or forwarded
  logic [31:0] s1_pix;
  logic [31:0] prev_pix_r;
  logic [HistAw-1:0] s1_addr_r;

  lzpd_history u_hist (
    .clk(clk), .wr(wr_c), .rd_en(adv), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_comb begin
    logic [CntW-1:0] ci;
    logic [24:0]     lsum;
    logic [17:0]     off;
    logic            fin;
    logic            lit_done;
    ci = cnt_r; lsum = '0; off = '0; fin = 1'b0; lit_done = 1'b0;
    total = (total_r > MAX_PIXELS_C) ? MAX_PIXELS_C : total_r;
    ph_nxt = ph_r; len_nxt = len_r; mofs_nxt = mofs_r; lits_nxt = lits_r;
    gat_nxt = gat_r; src_nxt = src_r; cnt_nxt = cnt_r;
    r_nxt = '0;
    wr_c = '0;
    rd_addr = src_r[HistAw-1:0];
    if (in_frame_start) begin
      ph_nxt = PH_CTRL; len_nxt = '0; mofs_nxt = '0; lits_nxt = '0;
      gat_nxt = '0; src_nxt = '0; cnt_nxt = '0; ci = '0;
    end
    if (ci < total) begin
      if (ph_nxt == PH_COPY) begin
        rd_addr = src_nxt[HistAw-1:0];
        r_nxt.is_copy = 1'b1;
        r_nxt.fwd = s1_r.pv && (s1_addr_r == src_nxt[HistAw-1:0]);
        r_nxt.pv  = 1'b1;
        r_nxt.idx = ci[23:0];
        r_nxt.cw  = !alpha_only_r;
        r_nxt.aw  = alpha_only_r || force_opaque_r;
        cnt_nxt   = ci + 1'b1;
        src_nxt   = src_nxt + 24'd1;
        len_nxt   = (len_nxt != '0) ? len_nxt - 1'b1 : '0;
        if (len_nxt == '0) begin
          ph_nxt = PH_CTRL;
        end else if (cnt_nxt >= total) begin
          r_nxt.err = ERR_TRUNC; len_nxt = '0; ph_nxt = PH_CTRL;
        end
      end else if (in_byte_valid) begin
        r_nxt.taken = 1'b1;
        case (ph_nxt)
          PH_LIT0: begin
            if (alpha_only_r) begin
              r_nxt.pv = 1'b1; r_nxt.aw = 1'b1; r_nxt.a = in_stream_byte;
              lit_done = 1'b1;
            end else begin
              gat_nxt = {8'd0, in_stream_byte}; ph_nxt = PH_LIT1;
            end
          end
          PH_LIT1: begin
            gat_nxt = {in_stream_byte, gat_nxt[7:0]}; ph_nxt = PH_LIT2;
          end
          PH_LIT2: begin
            r_nxt.pv = 1'b1; r_nxt.cw = 1'b1; r_nxt.aw = force_opaque_r;
            r_nxt.b0 = in_stream_byte; r_nxt.b1 = gat_nxt[15:8];
            r_nxt.b2 = gat_nxt[7:0]; r_nxt.a = 8'hFF;
            lit_done = 1'b1;
          end
          PH_EXT: begin
            lsum = {1'b0, len_nxt} + 25'(in_stream_byte);
            len_nxt = lsum[24] ? LEN_MAX : lsum[LenW-1:0];
            if (in_stream_byte != 8'hFF) ph_nxt = PH_OFS;
          end
          PH_OFS: begin
            if (in_stream_byte == 8'hFF && mofs_nxt == LONG_MARK) begin
              ph_nxt = PH_LONG_HI;
            end else begin
              off = 18'(mofs_nxt) + 18'(in_stream_byte) + 18'd1; fin = 1'b1;
            end
          end
          PH_LONG_HI: begin
            gat_nxt = {8'd0, in_stream_byte}; ph_nxt = PH_LONG_LO;
          end
          PH_LONG_LO: begin
            off = 18'({gat_nxt[7:0], in_stream_byte}) + 18'(LONG_BASE); fin = 1'b1;
          end
          default: begin
            if (in_stream_byte < 8'd32) begin
              lits_nxt = 6'(in_stream_byte) + 6'd1; ph_nxt = PH_LIT0;
            end else begin
              len_nxt  = LenW'(in_stream_byte[7:5]) - LenW'(1);
              mofs_nxt = {4'd0, in_stream_byte[4:0], 8'd0};
              ph_nxt   = (in_stream_byte[7:5] == 3'd7) ? PH_EXT : PH_OFS;
            end
          end
        endcase
        if (fin) begin
          lsum = {1'b0, len_nxt} + (alpha_only_r ? 25'd3 : 25'd1);
          len_nxt  = lsum[24] ? LEN_MAX : lsum[LenW-1:0];
          mofs_nxt = off[16:0];
          if (CntW'(off) > ci || off > 18'(HistoryDepth)) begin
            r_nxt.err = ERR_OFS; len_nxt = '0; ph_nxt = PH_CTRL;
          end else begin
            src_nxt = 24'(ci - CntW'(off)); ph_nxt = PH_COPY;
          end
        end
        if (r_nxt.pv) begin
          r_nxt.idx = ci[23:0];
          cnt_nxt = ci + 1'b1;
        end
        if (lit_done) begin
          lits_nxt = (lits_nxt != '0) ? lits_nxt - 1'b1 : '0;
          ph_nxt = PH_LIT0;
          if (lits_nxt == '0) begin
            ph_nxt = PH_CTRL;
          end else if (cnt_nxt >= total) begin
            r_nxt.err = ERR_TRUNC; lits_nxt = '0; ph_nxt = PH_CTRL;
          end
        end
      end
    end
    r_nxt.done = cnt_nxt >= total;
    // write the stage-1 pixel (copy data now resolved)
    wr_c.en   = s1_v_r && adv && s1_r.pv;
    wr_c.addr = s1_addr_r;
    wr_c.b0 = s1_pix[7:0]; wr_c.b1 = s1_pix[15:8];
    wr_c.b2 = s1_pix[23:16]; wr_c.a = s1_pix[31:24];
    wr_c.cw = s1_r.cw; wr_c.aw = s1_r.aw;
  end

  assign s1_pix = !s1_r.is_copy ? {s1_r.a, s1_r.b2, s1_r.b1, s1_r.b0}
                : (s1_r.fwd ? prev_pix_r : rd_data);

  // whole pixel forwarded; a lane the current mode never writes is never read back
  logic [31:0] merged;
  always_comb begin
    merged = s1_pix;
  end

  // output word: lanes not written read as zero
  always_comb begin
    out_nxt    = s1_r;
    out_nxt.b0 = s1_r.cw ? s1_pix[7:0] : 8'd0;
    out_nxt.b1 = s1_r.cw ? s1_pix[15:8] : 8'd0;
    out_nxt.b2 = s1_r.cw ? s1_pix[23:16] : 8'd0;
    out_nxt.a  = s1_r.aw ? s1_pix[31:24] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_CTRL; len_r <= '0; mofs_r <= '0; lits_r <= '0;
      gat_r <= '0; src_r <= '0; cnt_r <= '0;
      s1_v_r <= 1'b0; out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= fire;
      out_v_r <= s1_v_r;
      if (fire) begin
        ph_r <= ph_nxt; len_r <= len_nxt; mofs_r <= mofs_nxt; lits_r <= lits_nxt;
        gat_r <= gat_nxt; src_r <= src_nxt; cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fire) begin
        s1_r <= r_nxt;
        s1_addr_r <= r_nxt.idx[HistAw-1:0];
      end else begin
        s1_r.pv <= 1'b0;
      end
      if (s1_v_r && s1_r.pv) prev_pix_r <= merged;
      out_r <= out_nxt;
    end
  end

  assign out_byte_taken   = out_r.taken;
  assign out_pixel_valid  = out_r.pv;
  assign out_pixel_index  = out_r.idx;
  assign out_out_byte0    = out_r.b0;
  assign out_out_byte1    = out_r.b1;
  assign out_out_byte2    = out_r.b2;
  assign out_alpha_value  = out_r.a;
  assign out_colour_write = out_r.cw;
  assign out_alpha_write  = out_r.aw;
  assign out_frame_done   = out_r.done;
  assign out_error_code   = out_r.err;

endmodule
